### rtl/pptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback position timer package
// Shared item types, request and register codes, and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package pptc_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_PLAY = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;
  localparam logic [1:0] REQ_SET  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RESET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_STOP   = 3'd4;

  // Arithmetic widths.
  localparam int POS_W    = 32;                 // position and duration
  localparam int SPEED_W  = 16;                 // signed 8.8
  localparam int SPEED_FB = 8;                  // speed fraction bits
  localparam int PROD_W   = POS_W + SPEED_W;    // full step product
  localparam int STEP_W   = PROD_W - SPEED_FB;  // step after dropping speed fraction
  localparam int SUM_W    = STEP_W + 1;         // position plus step, signed
  localparam int DIV_W    = STEP_W;             // wrap dividend magnitude
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [31:0] delta_time;
    logic [31:0]       new_position;
  } in_item_t;

  typedef struct packed {
    logic [31:0] position;
    logic        playing;
    logic        finished;
    logic [7:0]  cycle_count;
    logic        state_changed;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the accepted input item
    logic mul;       // register delta_time * speed
    logic sum;       // register position + step
    logic div_load;  // seed the wrap divider
    logic div_step;  // one restoring division step
    logic commit;    // update state and the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;  // playing tick lies past an end, cyclic mode, nonzero duration
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

endpackage

### rtl/pptc_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic item channel with a source and a sink side.
// ----------------------------------------------------------------------------
interface pptc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/playback_position_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback position timer core
// Looping playback position counter in unsigned 16.16 fixed point.
// ----------------------------------------------------------------------------
// One item is handled at a time. A play, stop or set request, a tick while
// stopped, and a tick that stays inside the clip or clamps at an end pass
// through capture, step multiply, position sum, end check and commit. Commit
// writes the result into the output register and waits while that register
// still holds an untaken result. A tick that runs past an end in cyclic mode
// also passes through the restoring divider, which computes the wrapped
// position and the wrap count one quotient bit per cycle. The next item is
// accepted in the cycle after the previous result has been committed, even
// while that result still waits to be taken. Configuration writes are always
// ready and take effect on the next cycle.
module playback_position_timer_core
  import pptc_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  pptc_chan_if.sink   in_if,
  pptc_chan_if.source out_if,
  pptc_chan_if.sink   cfg_if
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  in_item_t  in_item;
  cfg_item_t cfg_item;
  out_item_t out_item;

  assign in_item     = in_if.data;
  assign cfg_item    = cfg_if.data;
  assign out_if.data = out_item;
  assign cfg_if.ready = 1'b1;

  pptc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pptc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_item),
    .cfg_valid (cfg_if.valid),
    .cfg_data  (cfg_item),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### rtl/pptc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback position timer controller
// Sequences one item through multiply, sum, end check, wrap divide and commit.
// ----------------------------------------------------------------------------
module pptc_ctrl
  import pptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.need_div) begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the finished result until the output register frees up.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/pptc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playback position timer datapath
// Configuration registers, position state, step multiplier, wrap divider and
// the output register.
// ----------------------------------------------------------------------------
module pptc_dp
  import pptc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_valid,
  input  cfg_item_t cfg_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts
);

  // Configuration.
  logic [POS_W-1:0]          dur_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic                      cyclic_r, auto_reset_r, auto_stop_r;

  // Architectural state.
  logic [POS_W-1:0] play_pos_r, play_pos_nxt;
  logic             playing_r, playing_nxt;

  // Working registers.
  in_item_t                  item_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   pos_r;
  logic [DIV_W-1:0]          quo_r;
  logic [POS_W-1:0]          rem_r;

  // Output register.
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W-1:0]  dur_s;
  logic                     past_end, before_start;
  logic [POS_W:0]           rem_sh;
  logic                     q_bit;
  logic                     q_big;
  logic [7:0]               k_fwd, k_bwd;

  assign dur_s        = $signed({{(SUM_W-POS_W){1'b0}}, dur_r});
  assign past_end     = pos_r > dur_s;
  assign before_start = pos_r[SUM_W-1];
  // The arithmetic shift floors toward minus infinity.
  assign step         = STEP_W'(prod_r >>> SPEED_FB);

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign q_bit  = rem_sh >= {1'b0, dur_r};

  assign q_big = |quo_r[DIV_W-1:8];
  assign k_fwd = q_big ? 8'hFF : quo_r[7:0];
  assign k_bwd = (q_big || quo_r[7:0] == 8'hFF) ? 8'hFF : quo_r[7:0] + 8'd1;

  assign sts.need_div = (item_r.req_type == REQ_TICK) && playing_r && (dur_r != '0)
                        && cyclic_r && (past_end || before_start);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Result of the current item; valid once the controller reaches commit.
  always_comb begin
    play_pos_nxt = play_pos_r;
    playing_nxt  = playing_r;
    out_nxt      = '0;
    case (item_r.req_type)
      REQ_PLAY: begin
        if (!playing_r && auto_reset_r) begin
          play_pos_nxt = '0;
        end
        playing_nxt           = 1'b1;
        out_nxt.state_changed = 1'b1;
      end
      REQ_STOP: begin
        playing_nxt           = 1'b0;
        out_nxt.state_changed = 1'b1;
      end
      REQ_SET: begin
        play_pos_nxt = (item_r.new_position < dur_r) ? item_r.new_position : dur_r;
      end
      REQ_TICK: begin
        if (playing_r) begin
          if (dur_r == '0) begin
            play_pos_nxt = '0;
            if (cyclic_r) begin
              out_nxt.cycle_count = 8'd1;
            end else begin
              out_nxt.finished = 1'b1;
              if (auto_stop_r) begin
                playing_nxt = 1'b0;
              end
            end
          end else if (past_end || before_start) begin
            if (cyclic_r) begin
              // Forward: position is remainder + 1. Backward: duration - 1 - remainder.
              if (past_end) begin
                play_pos_nxt        = rem_r + 1'b1;
                out_nxt.cycle_count = k_fwd;
              end else begin
                play_pos_nxt        = dur_r - rem_r - 1'b1;
                out_nxt.cycle_count = k_bwd;
              end
            end else begin
              play_pos_nxt     = past_end ? dur_r : '0;
              out_nxt.finished = 1'b1;
              if (auto_stop_r) begin
                playing_nxt = 1'b0;
              end
            end
          end else begin
            play_pos_nxt = pos_r[POS_W-1:0];
          end
        end
      end
      default: begin
        play_pos_nxt = play_pos_r;
      end
    endcase
    out_nxt.position = play_pos_nxt;
    out_nxt.playing  = playing_nxt;
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r        <= '0;
      speed_r      <= SPEED_RESET;
      cyclic_r     <= 1'b0;
      auto_reset_r <= 1'b0;
      auto_stop_r  <= 1'b1;
      play_pos_r   <= '0;
      playing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_data.index)
          CFG_DURATION:    dur_r        <= cfg_data.value;
          CFG_SPEED:       speed_r      <= cfg_data.value[SPEED_W-1:0];
          CFG_CYCLIC_MODE: cyclic_r     <= cfg_data.value[0];
          CFG_AUTO_RESET:  auto_reset_r <= cfg_data.value[0];
          CFG_AUTO_STOP:   auto_stop_r  <= cfg_data.value[0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        play_pos_r  <= play_pos_nxt;
        playing_r   <= playing_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.mul) begin
      prod_r <= item_r.delta_time * speed_r;
    end
    if (cmd.sum) begin
      pos_r <= $signed({{(SUM_W-POS_W){1'b0}}, play_pos_r}) + SUM_W'(step);
    end
    // Dividend is pos - 1 past the end and -pos - 1 (bitwise inverse) before start.
    if (cmd.div_load) begin
      quo_r <= past_end ? DIV_W'(pos_r - 1'b1) : DIV_W'(~pos_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
      rem_r <= q_bit ? POS_W'(rem_sh - {1'b0, dur_r}) : rem_sh[POS_W-1:0];
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

endmodule
